/* rtl/ump_pkg.sv */
// ----------------------------------------------------------------------------
// ump_pkg: shared types and constants of the unsharp mask filter
// payload structs, effective configuration, job record, back end states and
// the gaussian tap table
// ----------------------------------------------------------------------------
package ump_pkg;

  localparam int COL_W      = 12;
  localparam int ROW_W      = 13;
  localparam int DIM_W      = 13;
  localparam int KH_W       = 2;
  localparam int THR_W      = 11;
  localparam int GAIN_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HALF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic [KH_W-1:0]         half;
    logic signed [THR_W-1:0] threshold;
    logic [GAIN_W-1:0]       gain;
  } cfg_eff_t;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [COL_W-1:0] col;
    logic             due;
    logic             border;
    logic             eof;
  } job_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [2:0] count;
  } q_stat_t;

  typedef struct packed {
    logic pos_zero;
  } front_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_SHIFT,
    BK_MAC,
    BK_MACEND,
    BK_SCALE,
    BK_RESULT
  } back_state_t;

  // q0.16 taps of a sigma 1 gaussian, rows sum to 65536
  function automatic logic [15:0] tap(input logic [KH_W-1:0] half,
                                      input logic [KH_W-1:0] d);
    logic [15:0] t;
    t = 16'd0;
    if (half == 2'd3) begin
      case (d)
        2'd0:    t = 16'd26152;
        2'd1:    t = 16'd15862;
        2'd2:    t = 16'd3539;
        default: t = 16'd291;
      endcase
    end else begin
      case (d)
        2'd0:    t = 16'd26386;
        2'd1:    t = 16'd16004;
        2'd2:    t = 16'd3571;
        default: t = 16'd0;
      endcase
    end
    return t;
  endfunction

endpackage

/* rtl/unsharp_mask_filter.sv */
// ----------------------------------------------------------------------------
// unsharp_mask_filter: gaussian unsharp masking of a raster grey stream
// a result leaves with the transaction kernel_half rows plus kernel_half
// pixels after its pixel; the back end takes one job at a time through load,
// shift, tap multiply-accumulate, scale and result, and its throughput is set
// by the single tap multiply-accumulate; a border pixel skips the blur and
// a warm-up pixel leaves the back end after the window shift
// reset: synchronous active low; registers take their reset values, window
// clears, line stores stay unwritten
// ----------------------------------------------------------------------------
module unsharp_mask_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ump_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ump_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [ump_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ump_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ump_pkg::*;

  localparam int KH_CAP = (MAX_KERNEL - 1) / 2;
  localparam int KH_MAX = (KH_CAP > 3) ? 3 : KH_CAP;

  // configuration registers
  logic [10:0]             width_r;
  logic [12:0]             height_r;
  logic [KH_W-1:0]         half_r;
  logic signed [THR_W-1:0] thr_r;
  logic [GAIN_W-1:0]       gain_r;

  cfg_eff_t    cfg_eff;
  job_t        f_job, q_job;
  logic        f_push, q_pop;
  q_stat_t     q_stat;
  front_stat_t f_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd768;
      half_r   <= 2'd2;
      thr_r    <= '0;
      gain_r   <= 12'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[12:0];
        REG_KERNEL_HALF:  half_r   <= cfg_wdata[KH_W-1:0];
        REG_THRESHOLD:    thr_r    <= $signed(cfg_wdata[THR_W-1:0]);
        REG_GAIN:         gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their working ranges
  always_comb begin
    cfg_eff.width = DIM_W'(width_r);
    if (width_r < 11'd8) cfg_eff.width = DIM_W'(8);
    if (DIM_W'(width_r) > DIM_W'(MAX_WIDTH)) cfg_eff.width = DIM_W'(MAX_WIDTH);
    cfg_eff.height = height_r;
    if (height_r < 13'd8) cfg_eff.height = DIM_W'(8);
    if (height_r > 13'd4096) cfg_eff.height = DIM_W'(4096);
    cfg_eff.half = (half_r < 2'd2) ? 2'd2 : half_r;
    if (cfg_eff.half > KH_W'(KH_MAX)) cfg_eff.half = KH_W'(KH_MAX);
    cfg_eff.threshold = thr_r;
    cfg_eff.gain      = gain_r;
  end

  // front: positions, flush handling, border and end of frame marks
  ump_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_eff),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .q_full   (q_stat.full),
    .push     (f_push),
    .job      (f_job),
    .stat     (f_stat)
  );

  // short job queue between the two halves
  ump_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_job),
    .pop   (q_pop),
    .dout  (q_job),
    .stat  (q_stat)
  );

  // back: line stores, window, blur accumulate, sharpen, output register
  ump_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_eff),
    .q_empty   (q_stat.empty),
    .job_in    (q_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue occupancy stays within its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= 3'd4)
    else $error("job queue overfilled");

  // a job closing the frame returns every position to zero
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (f_push && f_job.due && f_job.eof) |=> f_stat.pos_zero)
    else $error("positions not cleared at end of frame");

  // kernel half stays within the supported range
  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_eff.half >= 2'd2) && (cfg_eff.half <= KH_W'(KH_MAX)))
    else $error("kernel half out of range");

endmodule

/* rtl/ump_front.sv */
// ----------------------------------------------------------------------------
// ump_front: position tracking and classification
// keeps input and output raster positions, drops flushes inside a frame and hands one
// job per kept transaction to the queue
// ----------------------------------------------------------------------------
module ump_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ump_pkg::cfg_eff_t     cfg,
  input  logic                  in_valid,
  input  ump_pkg::in_item_t     in_data,
  output logic                  in_ready,
  input  logic                  q_full,
  output logic                  push,
  output ump_pkg::job_t         job,
  output ump_pkg::front_stat_t  stat
);
  import ump_pkg::*;

  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic             accept, drop, live, due, border, eof;
  logic             wrap_in, wrap_out, wrap_in1, wrap_out1;
  logic [COL_W-1:0] ic, oc;
  logic [ROW_W-1:0] ir, orow, kr;
  logic [DIM_W-1:0] ic1, oc1;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    kr        = ROW_W'(cfg.half);
    wrap_in   = DIM_W'(in_col_r) >= cfg.width;
    ic        = wrap_in ? '0 : in_col_r;
    ir        = wrap_in ? in_row_r + 1'b1 : in_row_r;
    wrap_out  = DIM_W'(out_col_r) >= cfg.width;
    oc        = wrap_out ? '0 : out_col_r;
    orow      = wrap_out ? out_row_r + 1'b1 : out_row_r;
    live      = ir < cfg.height;
    drop      = live && in_data.flush;
    due       = (ir > kr) || ((ir == kr) && (ic >= COL_W'(cfg.half)));
    ic1       = DIM_W'(ic) + 1'b1;
    wrap_in1  = ic1 >= cfg.width;
    oc1       = DIM_W'(oc) + 1'b1;
    wrap_out1 = oc1 >= cfg.width;
    border    = !((orow >= kr) && ((ROW_W+1)'(orow) + (ROW_W+1)'(kr) < (ROW_W+1)'(cfg.height))
                && (oc >= COL_W'(cfg.half))
                && ((DIM_W+1)'(oc) + (DIM_W+1)'(cfg.half) < (DIM_W+1)'(cfg.width)));
    eof       = ((ROW_W+1)'(orow) + 1'b1 >= (ROW_W+1)'(cfg.height)) && (oc1 >= cfg.width);

    job.pixel  = live ? in_data.pixel : 8'd0;
    job.col    = ic;
    job.due    = due;
    job.border = border;
    job.eof    = eof;
    push       = accept && !drop;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept) begin
      out_col_nxt = oc;
      out_row_nxt = orow;
      if (drop) begin
        in_col_nxt = ic;
        in_row_nxt = ir;
      end else begin
        in_col_nxt = wrap_in1 ? '0 : ic1[COL_W-1:0];
        in_row_nxt = wrap_in1 ? ir + 1'b1 : ir;
        if (due) begin
          if (eof) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else begin
            out_col_nxt = wrap_out1 ? '0 : oc1[COL_W-1:0];
            out_row_nxt = wrap_out1 ? orow + 1'b1 : orow;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign stat.pos_zero = (in_col_r == '0) && (in_row_r == '0)
                      && (out_col_r == '0) && (out_row_r == '0);

endmodule

/* rtl/ump_queue.sv */
// ----------------------------------------------------------------------------
// ump_queue: four entry job queue
// decouples classification from the filter datapath
// ----------------------------------------------------------------------------
module ump_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ump_pkg::job_t     din,
  input  logic              pop,
  output ump_pkg::job_t     dout,
  output ump_pkg::q_stat_t  stat
);
  import ump_pkg::*;

  localparam int DEPTH = 4;

  job_t       mem_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + 3'(push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = count_r == 3'(DEPTH);
  assign stat.empty = count_r == 3'd0;
  assign stat.count = count_r;

endmodule

/* rtl/ump_back.sv */
// ----------------------------------------------------------------------------
// ump_back: line stores, window and sharpening datapath
// shifts line stores and window per job, accumulates the blur one tap a cycle
// and drives the output register
// ----------------------------------------------------------------------------
module ump_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ump_pkg::cfg_eff_t  cfg,
  input  logic               q_empty,
  input  ump_pkg::job_t      job_in,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ump_pkg::out_item_t out_data
);
  import ump_pkg::*;

  localparam int KH_CAP = (MAX_KERNEL - 1) / 2;
  localparam int KH_MAX = (KH_CAP > 3) ? 3 : KH_CAP;
  localparam int WK     = 2 * KH_MAX + 1;
  localparam int ROWS   = 2 * KH_MAX;
  localparam int DEPTH  = ROWS * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int IW     = $clog2(WK);

  back_state_t state_r, state_nxt;

  job_t        job_r, job_nxt;
  logic [2:0]  t_r, t_nxt, mj_r, mj_nxt, mi_r, mi_nxt;
  logic [7:0]  col_r [WK];
  logic [7:0]  col_nxt [WK];
  logic [7:0]  win_r [WK][WK];
  logic [7:0]  win_nxt [WK][WK];
  logic [7:0]  scan_r [WK][WK];
  logic [7:0]  scan_nxt [WK][WK];
  logic [7:0]  pix_r, pix_nxt, orig_r, orig_nxt;
  logic [31:0] wt_r, wt_nxt;
  logic        pv_r, pv_nxt;
  logic [40:0] acc_r, acc_nxt;
  logic signed [30:0] scaled_r, scaled_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata_r;
  logic [AW-1:0] addr;
  logic        mem_we;
  logic [7:0]  mem_wdata;

  logic [2:0]  ksz, klast;
  logic        out_free;

  logic [KH_W-1:0]    dj, di;
  logic [7:0]         orig;
  logic [40:0]        rnd;
  logic [16:0]        s;
  logic signed [17:0] diff;
  logic signed [30:0] dx, gx;
  logic signed [31:0] thrs, sc32;
  logic signed [32:0] val;
  logic [7:0]         res;

  assign ksz      = {cfg.half, 1'b1};
  assign klast    = ksz - 1'b1;
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == BK_IDLE) && !q_empty;

  // line store: read before write at the same address
  assign addr      = AW'(int'(t_r) * MAX_WIDTH + int'(job_r.col));
  assign mem_we    = (state_r == BK_LOAD) && (t_r < klast);
  assign mem_wdata = (t_r == 3'd0) ? job_r.pixel : rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    rdata_r <= mem[addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (!q_empty) state_nxt = BK_LOAD;
      BK_LOAD:   if (t_r == klast) state_nxt = BK_SHIFT;
      BK_SHIFT: begin
        if (!job_r.due) state_nxt = BK_IDLE;
        else if (job_r.border) state_nxt = BK_SCALE;
        else state_nxt = BK_MAC;
      end
      BK_MAC:    if ((mj_r == klast) && (mi_r == klast)) state_nxt = BK_MACEND;
      BK_MACEND: state_nxt = BK_SCALE;
      BK_SCALE:  state_nxt = BK_RESULT;
      BK_RESULT: if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_nxt    = job_r;
    t_nxt      = t_r;
    mj_nxt     = mj_r;
    mi_nxt     = mi_r;
    col_nxt    = col_r;
    win_nxt    = win_r;
    scan_nxt   = scan_r;
    pix_nxt    = pix_r;
    wt_nxt     = wt_r;
    pv_nxt     = 1'b0;
    orig_nxt   = orig_r;
    scaled_nxt = scaled_r;
    out_nxt    = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    acc_nxt    = pv_r ? acc_r + 41'(pix_r) * 41'(wt_r) : acc_r;

    dj   = (mj_r >= 3'(cfg.half)) ? KH_W'(mj_r - 3'(cfg.half)) : KH_W'(3'(cfg.half) - mj_r);
    di   = (mi_r >= 3'(cfg.half)) ? KH_W'(mi_r - 3'(cfg.half)) : KH_W'(3'(cfg.half) - mi_r);
    orig = win_r[IW'(cfg.half)][IW'(cfg.half)];
    rnd  = acc_r + 41'(1 << 23);
    s    = rnd[40:24];
    diff = $signed({2'b00, orig, 8'h00}) - $signed({1'b0, s});
    dx   = 31'(diff);
    gx   = $signed({19'b0, cfg.gain});
    thrs = {{5{cfg.threshold[THR_W-1]}}, cfg.threshold, 16'h0000};
    sc32 = 32'(scaled_r);
    val  = $signed({9'b0, orig_r, 16'h0000}) + 33'(scaled_r) + 33'sd32768;
    if (sc32 < thrs) res = orig_r;
    else if (val < 0) res = 8'd0;
    else if (val[32:16] > 17'd255) res = 8'd255;
    else res = val[23:16];

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          job_nxt = job_in;
          t_nxt   = '0;
        end
      end
      BK_LOAD: begin
        t_nxt = t_r + 1'b1;
        for (int j = 0; j < WK; j++) begin
          if ((t_r == 3'd0) && (3'(j) == klast)) col_nxt[j] = job_r.pixel;
          if ((t_r != 3'd0) && (3'(j) == klast - t_r)) col_nxt[j] = rdata_r;
        end
      end
      BK_SHIFT: begin
        for (int j = 0; j < WK; j++) begin
          for (int i = 0; i < WK - 1; i++) begin
            if ((3'(j) < ksz) && (3'(i) < klast)) win_nxt[j][i] = win_r[j][i+1];
          end
          for (int i = 0; i < WK; i++) begin
            if ((3'(j) < ksz) && (3'(i) == klast)) win_nxt[j][i] = col_r[j];
          end
        end
        scan_nxt = win_nxt;
        acc_nxt  = '0;
        mj_nxt   = '0;
        mi_nxt   = '0;
      end
      BK_MAC: begin
        pix_nxt = scan_r[0][0];
        wt_nxt  = 32'(tap(cfg.half, dj)) * 32'(tap(cfg.half, di));
        pv_nxt  = 1'b1;
        if (mi_r == klast) begin
          mi_nxt = '0;
          mj_nxt = mj_r + 1'b1;
          for (int j = 0; j < WK - 1; j++) scan_nxt[j] = scan_r[j+1];
        end else begin
          mi_nxt = mi_r + 1'b1;
          for (int i = 0; i < WK - 1; i++) scan_nxt[0][i] = scan_r[0][i+1];
        end
      end
      BK_SCALE: begin
        orig_nxt   = orig;
        scaled_nxt = dx * gx;
      end
      BK_RESULT: begin
        if (out_free) begin
          out_nxt.out_pixel    = res;
          out_nxt.end_of_frame = job_r.eof;
          out_valid_nxt        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '{default: '{default: 8'd0}};
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    t_r      <= t_nxt;
    mj_r     <= mj_nxt;
    mi_r     <= mi_nxt;
    col_r    <= col_nxt;
    scan_r   <= scan_nxt;
    pix_r    <= pix_nxt;
    wt_r     <= wt_nxt;
    acc_r    <= acc_nxt;
    orig_r   <= orig_nxt;
    scaled_r <= scaled_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sim/unsharp_mask_filter_test.sv */
// ----------------------------------------------------------------------------
// unsharp_mask_filter_test: self-checking bench for the unsharp mask filter
// whole frames of grey pixels go through the block under a range of sizes,
// kernels, thresholds and gains; a built-in sharpening predictor works out each
// enhanced pixel, and every result transaction is checked field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unsharp_mask_filter_test;
  import ump_pkg::*;

  localparam int STORE_W = 1024;

  // q0.16 gaussian taps by distance from the center, sigma 1
  localparam int unsigned TAPS5 [4] = '{26386, 16004, 3571, 0};
  localparam int unsigned TAPS7 [4] = '{26152, 15862, 3539, 291};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  unsharp_mask_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // pixels waiting to be driven, and enhanced pixels still owed by the block
  in_item_t  pixel_queue [$];
  out_item_t expected_pixels [$];

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int pixels_sent;

  // predictor copy of the block: line stores, window, raster positions
  logic [7:0] line_rows [0:6*STORE_W-1];
  logic [7:0] win [0:48];
  int unsigned in_col, in_row_pos, out_col, out_row_pos;

  // predictor copy of the registers
  logic [10:0]        reg_width;
  logic [12:0]        reg_height;
  logic [1:0]         reg_half;
  logic signed [10:0] reg_threshold;
  logic [11:0]        reg_gain;

  function automatic int unsigned frame_width();
    if (reg_width < 8) return 8;
    if (reg_width > STORE_W) return STORE_W;
    return reg_width;
  endfunction

  function automatic int unsigned frame_height();
    if (reg_height < 8) return 8;
    if (reg_height > 4096) return 4096;
    return reg_height;
  endfunction

  function automatic int unsigned kernel_radius();
    return (reg_half < 2) ? 2 : reg_half;
  endfunction

  function automatic void clear_predictor();
    foreach (line_rows[n]) line_rows[n] = 8'd0;
    foreach (win[n]) win[n] = 8'd0;
    in_col = 0;
    in_row_pos = 0;
    out_col = 0;
    out_row_pos = 0;
    reg_width = 11'd1024;
    reg_height = 13'd768;
    reg_half = 2'd2;
    reg_threshold = 11'sd0;
    reg_gain = 12'd256;
  endfunction

  // advance the raster model by one transaction; 1 when it yields a pixel
  function automatic bit sharpen_pixel(input in_item_t item, output out_item_t res);
    int unsigned w, h, k, kk, c, v, orig, j, i, dy, dx;
    int unsigned column [7];
    int unsigned taps [4];
    longint unsigned blur;
    longint diff, scaled, thr, sum;
    bit due, eof;
    w = frame_width();
    h = frame_height();
    k = kernel_radius();
    kk = 2 * k + 1;
    if (k == 3) taps = TAPS7;
    else taps = TAPS5;
    blur = 0;
    res = '0;

    if (in_col >= w) begin
      in_col = 0;
      in_row_pos++;
    end
    if (out_col >= w) begin
      out_col = 0;
      out_row_pos++;
    end
    // flush inside a frame does nothing
    if (in_row_pos < h && item.flush) return 0;
    v = (in_row_pos < h) ? item.pixel : 0;
    c = in_col;

    // column of the window, oldest row on top
    column[kk-1] = v;
    for (j = 0; j + 1 < kk; j++) column[kk-2-j] = line_rows[j*STORE_W + c];
    for (j = kk - 1; j > 1; j--) line_rows[(j-1)*STORE_W + c] = line_rows[(j-2)*STORE_W + c];
    line_rows[c] = v[7:0];
    for (j = 0; j < kk; j++) begin
      for (i = 0; i + 1 < kk; i++) win[j*7 + i] = win[j*7 + i + 1];
      win[j*7 + kk - 1] = column[j][7:0];
    end

    due = longint'(in_row_pos) * w + in_col >= longint'(k) * w + k;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row_pos++;
    end
    if (!due) return 0;

    orig = win[k*7 + k];
    // border ring keeps a zero blur
    if (out_row_pos >= k && out_row_pos + k < h && out_col >= k && out_col + k < w) begin
      for (j = 0; j < kk; j++) begin
        for (i = 0; i < kk; i++) begin
          dy = (j > k) ? j - k : k - j;
          dx = (i > k) ? i - k : k - i;
          blur += longint'(win[j*7 + i]) * (longint'(taps[dy]) * taps[dx]);
        end
      end
    end
    diff = longint'(orig) * 256 - longint'((blur + (64'd1 << 23)) >> 24);
    scaled = diff * longint'(reg_gain);
    thr = reg_threshold;
    if (scaled < thr * 65536) begin
      res.out_pixel = orig[7:0];
    end else begin
      sum = longint'(orig) * 65536 + scaled + 32768;
      if (sum < 0) res.out_pixel = 8'd0;
      else if ((sum >>> 16) > 255) res.out_pixel = 8'd255;
      else res.out_pixel = sum[23:16];
    end

    eof = (out_row_pos + 1 >= h) && (out_col + 1 >= w);
    res.end_of_frame = eof;
    if (eof) begin
      in_col = 0;
      in_row_pos = 0;
      out_col = 0;
      out_row_pos = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row_pos++;
      end
    end
    return 1;
  endfunction

  // driver: offers queued pixels, holds each one until its transaction
  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        if (sharpen_pixel(in_data, res)) expected_pixels.push_back(res);
      end
      // a pending transaction keeps valid and payload as they are
      if (!(in_valid && !in_ready)) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transaction: out_pixel %0d end_of_frame %0d",
                 out_data.out_pixel, out_data.end_of_frame);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %0d, got %0d", want.out_pixel, out_data.out_pixel);
            error_count++;
          end
          if (out_data.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0d, got %0d",
                   want.end_of_frame, out_data.end_of_frame);
            error_count++;
          end
        end
      end
      // long hold-off lets the block back up into its input
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_IMAGE_WIDTH:  reg_width = value[10:0];
      REG_IMAGE_HEIGHT: reg_height = value[12:0];
      REG_KERNEL_HALF:  reg_half = value[1:0];
      REG_THRESHOLD:    reg_threshold = value[10:0];
      REG_GAIN:         reg_gain = value[11:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned kh,
                           input int thr, input int unsigned g);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_KERNEL_HALF, kh);
    write_reg(REG_THRESHOLD, thr & 32'h7ff);
    write_reg(REG_GAIN, g);
  endtask

  // wait until every transaction is sent and answered, then let a job
  // without a result run out of the back end
  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // one whole frame at the current setting, followed by its drain items;
  // style: 0 random, 1 black and white, 2 ramp with noise, 3 checkerboard
  task automatic queue_frame(input int style, input bit stray_flushes);
    int unsigned w, h, k, r, c;
    in_item_t item;
    w = frame_width();
    h = frame_height();
    k = kernel_radius();
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        // flush in mid frame must be ignored
        if (stray_flushes && $urandom_range(99) < 4) begin
          item.pixel = 8'($urandom_range(255));
          item.flush = 1'b1;
          pixel_queue.push_back(item);
        end
        case (style)
          1: item.pixel = $urandom_range(1) ? 8'd255 : 8'd0;
          2: item.pixel = 8'((r * 13 + c * 7) + $urandom_range(15));
          3: item.pixel = ((r ^ c) & 1) ? 8'd255 : 8'd0;
          default: item.pixel = 8'($urandom_range(255));
        endcase
        item.flush = 1'b0;
        pixel_queue.push_back(item);
        pixels_sent++;
      end
    end
    // tail of the frame: any item drains, pixel ignored
    for (r = 0; r < k * w + k; r++) begin
      item.pixel = 8'($urandom_range(255));
      item.flush = ($urandom_range(9) != 0);
      pixel_queue.push_back(item);
      pixels_sent++;
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      1: begin send_idle_pct = 46; recv_idle_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_idle_pct = 46; end
      default: begin send_idle_pct = 32; recv_idle_pct = 32; end
    endcase
  endtask

  initial begin
    int phase;
    int thr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 0;
    pixels_sent = 0;
    clear_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small 8x8 frame of hard edges, 5x5 kernel, at the reset gain and threshold
    configure(8, 8, 2, 0, 256);
    queue_frame(3, 1'b0);
    wait_drained();
    // 7x7, maximal gain saturates both ways, lowest threshold
    configure(8, 8, 3, -1024, 4095);
    queue_frame(1, 1'b1);
    wait_drained();
    // out of range registers clamp: width, height and kernel below minimum,
    // highest threshold keeps every original, gain zero
    configure(3, 2, 0, 1023, 0);
    queue_frame(1, 1'b1);
    wait_drained();
    configure(9, 8191, 1, 0, 256);
    configure(9, 8, 1, 5, 600);
    queue_frame(2, 1'b0);

    // sender pauses until the block has answered everything
    wait_drained();
    // receiver holds off long enough to back the block up
    configure(12, 9, 3, -8, 1000);
    recv_hold_cycles = 3000;
    queue_frame(0, 1'b1);
    wait_drained();

    // random settings, all on small frames
    phase = 0;
    while (pixels_sent < 1950) begin
      set_idling(phase);
      if ($urandom_range(3) == 0) thr = $urandom_range(2047) - 1024;
      else thr = $urandom_range(64) - 32;
      configure($urandom_range(16, 8), $urandom_range(12, 8), $urandom_range(3),
                thr, $urandom_range(4095));
      queue_frame($urandom_range(3), 1'($urandom_range(1)));
      wait_drained();
      phase++;
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #80ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
